// File: rtl/core/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

    localparam int MAX_SEQ_BYTES = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2    = 21'h000080;
    localparam logic [20:0] MIN_LEN3    = 21'h000800;
    localparam logic [20:0] MIN_LEN4    = 21'h010000;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD = 3'd1;
    localparam logic [2:0] ST_BROKEN   = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic [2:0]  status;
        logic        last;
    } t_out_word;

    // Up to two result words caused by one input byte.
    typedef struct packed {
        logic      two;
        t_out_word w0;
        t_out_word w1;
    } t_pair;

endpackage

`default_nettype wire

// File: rtl/core/u8d_front.sv
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_word i_in_word,
    output logic          o_in_stall,
    input  wire logic     i_q_full,
    output logic          o_q_push,
    output t_pair         o_q_pair
);

    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_seen, n_seen;
    logic [20:0] r_acc, n_acc;

    logic [7:0]  b;
    logic        eot, accept, open, is_cont, bad_lead;
    logic        l_has, l_open;
    logic [2:0]  l_len;
    logic [20:0] l_bits;
    t_out_word   l_word;
    logic [20:0] acc_new, min_v;
    logic [2:0]  seen_new;
    logic        range_bad;

    assign b          = i_in_word.data_byte;
    assign eot        = i_in_word.end_of_text;
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign open       = (r_exp >= 3'd2) && (r_exp <= 3'(MAX_SEQ_BYTES)) &&
                        (r_seen != 3'd0) && (r_seen < r_exp);
    assign is_cont    = (b[7:6] == 2'b10);
    assign bad_lead   = is_cont || (b[7:3] == 5'b11111);
    assign acc_new    = {r_acc[14:0], b[5:0]};
    assign seen_new   = r_seen + 3'd1;

    // lead byte decode
    always_comb begin
        l_has  = 1'b1;
        l_open = 1'b0;
        l_len  = 3'd0;
        l_bits = '0;
        l_word = '{code_point: REPLACEMENT, byte_count: 3'd1,
                   status: ST_BAD_LEAD, last: 1'b1};
        if (!b[7]) begin
            l_word.code_point = {13'd0, b};
            l_word.status     = ST_OK;
        end else if (!bad_lead) begin
            if (!b[5]) begin
                l_len  = 3'd2;
                l_bits = {16'd0, b[4:0]};
            end else if (!b[4]) begin
                l_len  = 3'd3;
                l_bits = {17'd0, b[3:0]};
            end else begin
                l_len  = 3'd4;
                l_bits = {18'd0, b[2:0]};
            end
            if (eot) begin
                l_word.status = ST_TRUNC;
            end else begin
                l_has  = 1'b0;
                l_open = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_exp)
            3'd2:    min_v = MIN_LEN2;
            3'd3:    min_v = MIN_LEN3;
            3'd4:    min_v = MIN_LEN4;
            default: min_v = '0;
        endcase
    end

    assign range_bad = (acc_new < min_v) || (acc_new > MAX_CODE) ||
                       ((acc_new >= SURR_LO) && (acc_new <= SURR_HI));

    always_comb begin
        n_exp    = r_exp;
        n_seen   = r_seen;
        n_acc    = r_acc;
        o_q_push = 1'b0;
        o_q_pair = '{two: 1'b0, w0: l_word, w1: l_word};
        if (accept) begin
            if (!open) begin
                n_exp    = l_open ? l_len : 3'd0;
                n_seen   = l_open ? 3'd1 : 3'd0;
                n_acc    = l_open ? l_bits : '0;
                o_q_push = l_has;
            end else if (is_cont) begin
                n_acc  = acc_new;
                n_seen = seen_new;
                if (seen_new == r_exp) begin
                    o_q_push = 1'b1;
                    o_q_pair.w0 = '{code_point: range_bad ? REPLACEMENT : acc_new,
                                    byte_count: r_exp,
                                    status: range_bad ? ST_RANGE : ST_OK,
                                    last: 1'b1};
                    n_exp  = 3'd0;
                    n_seen = 3'd0;
                    n_acc  = '0;
                end else if (eot) begin
                    o_q_push = 1'b1;
                    o_q_pair.w0 = '{code_point: REPLACEMENT, byte_count: seen_new,
                                    status: ST_TRUNC, last: 1'b1};
                    n_exp  = 3'd0;
                    n_seen = 3'd0;
                    n_acc  = '0;
                end
            end else begin
                // close the broken sequence, then decode this byte afresh
                o_q_push     = 1'b1;
                o_q_pair.two = l_has;
                o_q_pair.w0  = '{code_point: REPLACEMENT, byte_count: r_seen,
                                 status: ST_BROKEN, last: !l_has};
                o_q_pair.w1  = l_word;
                n_exp  = l_open ? l_len : 3'd0;
                n_seen = l_open ? 3'd1 : 3'd0;
                n_acc  = l_open ? l_bits : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_seen <= '0;
            r_acc  <= '0;
        end else begin
            r_exp  <= n_exp;
            r_seen <= n_seen;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/u8d_queue.sv
`default_nettype none

module u8d_queue
    import u8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_pair i_pair,
    output logic       o_full,
    output logic       o_empty,
    output t_pair      o_head,
    input  wire logic  i_pop
);

    t_pair                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr, r_rd;
    logic [QPTR_W:0]      r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/u8d_back.sv
`default_nettype none

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_pair i_q_head,
    output logic       o_q_pop,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  wire logic  i_out_stall
);

    logic      r_valid, n_valid;
    logic      r_sel, n_sel;
    t_out_word r_word, n_word;
    logic      out_free;

    assign out_free    = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_word  = r_word;
        o_q_pop = 1'b0;
        if (out_free) begin
            n_valid = !i_q_empty;
            if (!i_q_empty) begin
                n_word = r_sel ? i_q_head.w1 : i_q_head.w0;
                if (r_sel || !i_q_head.two) begin
                    o_q_pop = 1'b1;
                    n_sel   = 1'b0;
                end else begin
                    n_sel = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// File: rtl/core/utf8_stream_decoder.sv
`default_nettype none
// Channel  Direction  Ports                                   Word
// in       input      i_in_valid, o_in_stall, i_in_word       one text byte, end_of_text flag
// out      output     o_out_valid, i_out_stall, o_out_word    code point, length, status, last
//
// One byte is taken per cycle while the result queue has room; the front part
// decodes it in that same cycle and pushes its results, if any, one or two as a pair.
// The back part sends one result per cycle from a registered output while
// i_out_stall is low; a pair with two results is popped when its second is loaded.
// A result passes through the queue and then the output register before it appears.
// Reset (i_rst_n low at a clock edge) closes any open sequence and empties the queue.
// o_in_stall is high only while the four-entry queue is full.

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_word,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_word      o_out_word,
    input  wire logic      i_out_stall
);

    logic  q_push, q_pop, q_full, q_empty;
    t_pair q_in, q_head;

    // Front: accept bytes, track the open sequence, form results.
    u8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_pair   (q_in)
    );

    // Queue: decouple byte intake from result delivery.
    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pair  (q_in),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // Back: split each pair into single words and hold them under stall.
    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
